FILE: rtl/core/gca_pkg.sv
package gca_pkg;

    localparam int COL_BITS   = 8;
    localparam int ROW_BITS   = 8;
    localparam int STATE_BITS = 8;
    localparam int ADDR_BITS  = COL_BITS + ROW_BITS;
    localparam int EXT_BITS   = 9;
    localparam int LIVE_BITS  = 4;

    localparam logic [EXT_BITS-1:0] MAX_WIDTH  = EXT_BITS'(1 << COL_BITS);
    localparam logic [EXT_BITS-1:0] MAX_HEIGHT = EXT_BITS'(1 << ROW_BITS);
    localparam logic [EXT_BITS-1:0] DYING_FIRST = EXT_BITS'(2);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_BAD_RULE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_STATE_COUNT  = 3'd0,
        REG_BIRTH_LOW    = 3'd1,
        REG_BIRTH_HIGH   = 3'd2,
        REG_SURVIVE_LOW  = 3'd3,
        REG_SURVIVE_HIGH = 3'd4,
        REG_WRAP_EDGES   = 3'd5,
        REG_GRID_WIDTH   = 3'd6,
        REG_GRID_HEIGHT  = 3'd7
    } reg_idx_t;

endpackage

FILE: rtl/core/generations_cellular_automaton_unit.sv
// Generations cellular automaton on a 256 by 256 grid of 8-bit cells held in two
// synchronous memories. After reset the block clears the grid, one cell a cycle,
// before it accepts its first transfer; configuration writes are taken throughout.
// A cell write or an out-of-range access shows its result in the next cycle, and an
// in-range cell read passes through a wait state for the registered memory read. A
// generation step visits the active cells one at a time: for each cell its eight
// neighbors and itself are read through the single read port of the current grid
// and then the new state is written, after which a copy pass moves each active
// cell's new state into the current grid. The next transfer is taken once the
// result has been handed on or is being taken.
module generations_cellular_automaton_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: op[1:0], col[9:2], row[17:10], write_state[25:18], zero fill.
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: read_state[7:0], status[9:8], zero fill.
    output logic [15:0] m_tdata
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD_WAIT, S_GEN_RD, S_GEN_WR, S_COPY_RD, S_COPY_WR
    } fsm_t;

    localparam int AB = gca_pkg::ADDR_BITS;
    localparam int CB = gca_pkg::COL_BITS;
    localparam int RB = gca_pkg::ROW_BITS;
    localparam int SB = gca_pkg::STATE_BITS;
    localparam int EB = gca_pkg::EXT_BITS;
    localparam int LB = gca_pkg::LIVE_BITS;

    logic [EB-1:0] state_count_reg;
    logic [3:0]    birth_low_reg, birth_high_reg, survive_low_reg, survive_high_reg;
    logic          wrap_edges_reg;
    logic [EB-1:0] grid_width_reg, grid_height_reg;

    fsm_t          fsm_reg;
    logic [AB-1:0] clr_reg;
    logic [CB-1:0] cx_reg;
    logic [RB-1:0] cy_reg;
    logic [3:0]    k_reg;
    logic [LB-1:0] live_reg;
    logic [SB-1:0] center_reg;
    logic          out_valid_reg;
    logic [SB-1:0] out_data_reg;
    logic [1:0]    out_status_reg;

    logic [SB-1:0] cur_mem [2**AB];
    logic [SB-1:0] nxt_mem [2**AB];
    logic [SB-1:0] cur_rd_reg, nxt_rd_reg;

    logic          cur_we, nxt_we;
    logic [AB-1:0] cur_waddr, cur_raddr;
    logic [SB-1:0] cur_wdata, nb_next_state;

    logic [1:0]    in_op;
    logic [CB-1:0] in_col;
    logic [RB-1:0] in_row;
    logic [SB-1:0] in_wstate;
    logic          in_accept, in_range, rule_bad;
    logic [EB-1:0] w_eff, h_eff;
    logic [CB-1:0] w_last, nx;
    logic [RB-1:0] h_last, ny;
    logic [1:0]    dx_sel, dy_sel;
    logic [AB-1:0] cell_addr;
    logic [LB-1:0] live_final;
    logic [EB-1:0] adv;
    logic          cell_last_col, cell_last_row;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[4:2])
            gca_pkg::REG_STATE_COUNT:  prdata = 32'(state_count_reg);
            gca_pkg::REG_BIRTH_LOW:    prdata = 32'(birth_low_reg);
            gca_pkg::REG_BIRTH_HIGH:   prdata = 32'(birth_high_reg);
            gca_pkg::REG_SURVIVE_LOW:  prdata = 32'(survive_low_reg);
            gca_pkg::REG_SURVIVE_HIGH: prdata = 32'(survive_high_reg);
            gca_pkg::REG_WRAP_EDGES:   prdata = 32'(wrap_edges_reg);
            gca_pkg::REG_GRID_WIDTH:   prdata = 32'(grid_width_reg);
            gca_pkg::REG_GRID_HEIGHT:  prdata = 32'(grid_height_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_count_reg  <= EB'(2);
            birth_low_reg    <= 4'd3;
            birth_high_reg   <= 4'd3;
            survive_low_reg  <= 4'd2;
            survive_high_reg <= 4'd3;
            wrap_edges_reg   <= 1'b1;
            grid_width_reg   <= gca_pkg::MAX_WIDTH;
            grid_height_reg  <= gca_pkg::MAX_HEIGHT;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                gca_pkg::REG_STATE_COUNT:  state_count_reg  <= pwdata[EB-1:0];
                gca_pkg::REG_BIRTH_LOW:    birth_low_reg    <= pwdata[3:0];
                gca_pkg::REG_BIRTH_HIGH:   birth_high_reg   <= pwdata[3:0];
                gca_pkg::REG_SURVIVE_LOW:  survive_low_reg  <= pwdata[3:0];
                gca_pkg::REG_SURVIVE_HIGH: survive_high_reg <= pwdata[3:0];
                gca_pkg::REG_WRAP_EDGES:   wrap_edges_reg   <= pwdata[0];
                gca_pkg::REG_GRID_WIDTH:   grid_width_reg   <= pwdata[EB-1:0];
                gca_pkg::REG_GRID_HEIGHT:  grid_height_reg  <= pwdata[EB-1:0];
                default:                   ;
            endcase
        end
    end

    assign in_op     = s_tdata[1:0];
    assign in_col    = s_tdata[2 +: CB];
    assign in_row    = s_tdata[2+CB +: RB];
    assign in_wstate = s_tdata[2+CB+RB +: SB];

    assign w_eff = (grid_width_reg == '0) ? EB'(1) :
                   (grid_width_reg > gca_pkg::MAX_WIDTH) ? gca_pkg::MAX_WIDTH : grid_width_reg;
    assign h_eff = (grid_height_reg == '0) ? EB'(1) :
                   (grid_height_reg > gca_pkg::MAX_HEIGHT) ? gca_pkg::MAX_HEIGHT :
                   grid_height_reg;
    assign w_last = CB'(w_eff - EB'(1));
    assign h_last = RB'(h_eff - EB'(1));

    assign s_tready  = (fsm_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;
    assign in_range  = (EB'(in_col) < w_eff) && (EB'(in_row) < h_eff);
    assign rule_bad  = (birth_low_reg > birth_high_reg) || (survive_low_reg > survive_high_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_status_reg, out_data_reg};

    // Neighbor k runs over the 3x3 window in row order; k = 4 is the cell itself.
    always_comb
    begin
        case (k_reg)
            4'd0, 4'd3, 4'd6: dx_sel = 2'd0;
            4'd1, 4'd4, 4'd7: dx_sel = 2'd1;
            default:          dx_sel = 2'd2;
        endcase
        if (k_reg < 4'd3)
            dy_sel = 2'd0;
        else if (k_reg < 4'd6)
            dy_sel = 2'd1;
        else
            dy_sel = 2'd2;

        if (dx_sel == 2'd0)
            nx = (cx_reg == '0) ? (wrap_edges_reg ? w_last : '0) : cx_reg - CB'(1);
        else if (dx_sel == 2'd2)
            nx = (cx_reg == w_last) ? (wrap_edges_reg ? '0 : w_last) : cx_reg + CB'(1);
        else
            nx = cx_reg;

        if (dy_sel == 2'd0)
            ny = (cy_reg == '0) ? (wrap_edges_reg ? h_last : '0) : cy_reg - RB'(1);
        else if (dy_sel == 2'd2)
            ny = (cy_reg == h_last) ? (wrap_edges_reg ? '0 : h_last) : cy_reg + RB'(1);
        else
            ny = cy_reg;
    end

    assign cell_addr     = {cy_reg, cx_reg};
    assign cell_last_col = (cx_reg == w_last);
    assign cell_last_row = (cy_reg == h_last);
    assign live_final    = live_reg + LB'(cur_rd_reg == SB'(1));
    assign adv           = EB'(center_reg) + EB'(1);

    always_comb
    begin
        if (center_reg == '0)
            nb_next_state = ((live_final >= birth_low_reg) && (live_final <= birth_high_reg))
                            ? SB'(1) : '0;
        else if (center_reg == SB'(1))
        begin
            if ((live_final >= survive_low_reg) && (live_final <= survive_high_reg))
                nb_next_state = SB'(1);
            else
                nb_next_state = (state_count_reg > gca_pkg::DYING_FIRST)
                                ? SB'(gca_pkg::DYING_FIRST) : '0;
        end
        else
            nb_next_state = ((adv < state_count_reg) && (adv <= EB'((1 << SB) - 1)))
                            ? SB'(adv) : '0;
    end

    always_comb
    begin
        cur_we    = 1'b0;
        cur_waddr = cell_addr;
        cur_wdata = nxt_rd_reg;
        cur_raddr = {in_row, in_col};
        nxt_we    = 1'b0;
        case (fsm_reg)
            S_CLEAR:
            begin
                cur_we    = 1'b1;
                cur_waddr = clr_reg;
                cur_wdata = '0;
            end
            S_IDLE:
            begin
                cur_we    = in_accept && (in_op == gca_pkg::OP_WRITE) && in_range;
                cur_waddr = {in_row, in_col};
                cur_wdata = in_wstate;
            end
            S_GEN_RD:  cur_raddr = {ny, nx};
            S_GEN_WR:  nxt_we = 1'b1;
            S_COPY_WR: cur_we = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
            cur_mem[cur_waddr] <= cur_wdata;
        cur_rd_reg <= cur_mem[cur_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
            nxt_mem[cell_addr] <= nb_next_state;
        nxt_rd_reg <= nxt_mem[cell_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= S_CLEAR;
            clr_reg        <= '0;
            cx_reg         <= '0;
            cy_reg         <= '0;
            k_reg          <= '0;
            live_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= gca_pkg::ST_OK;
            out_data_reg   <= '0;
            center_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (fsm_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AB'(1);
                    if (clr_reg == '1)
                        fsm_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        out_data_reg   <= '0;
                        out_status_reg <= gca_pkg::ST_OK;
                        case (in_op)
                            gca_pkg::OP_WRITE:
                            begin
                                out_valid_reg <= 1'b1;
                                if (!in_range)
                                    out_status_reg <= gca_pkg::ST_RANGE;
                            end
                            gca_pkg::OP_READ:
                            begin
                                if (in_range)
                                    fsm_reg <= S_RD_WAIT;
                                else
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_status_reg <= gca_pkg::ST_RANGE;
                                end
                            end
                            gca_pkg::OP_STEP:
                            begin
                                if (rule_bad)
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_status_reg <= gca_pkg::ST_BAD_RULE;
                                end
                                else
                                begin
                                    fsm_reg  <= S_GEN_RD;
                                    cx_reg   <= '0;
                                    cy_reg   <= '0;
                                    k_reg    <= '0;
                                    live_reg <= '0;
                                end
                            end
                            default: out_valid_reg <= 1'b1;
                        endcase
                    end
                end
                S_RD_WAIT:
                begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= cur_rd_reg;
                    fsm_reg       <= S_IDLE;
                end
                S_GEN_RD:
                begin
                    if (k_reg == 4'd5)
                        center_reg <= cur_rd_reg;
                    else if ((k_reg != '0) && (cur_rd_reg == SB'(1)))
                        live_reg <= live_reg + LB'(1);
                    if (k_reg == 4'd8)
                        fsm_reg <= S_GEN_WR;
                    else
                        k_reg <= k_reg + 4'd1;
                end
                S_GEN_WR:
                begin
                    k_reg    <= '0;
                    live_reg <= '0;
                    fsm_reg  <= S_GEN_RD;
                    if (cell_last_col)
                    begin
                        cx_reg <= '0;
                        if (cell_last_row)
                        begin
                            cy_reg  <= '0;
                            fsm_reg <= S_COPY_RD;
                        end
                        else
                            cy_reg <= cy_reg + RB'(1);
                    end
                    else
                        cx_reg <= cx_reg + CB'(1);
                end
                S_COPY_RD: fsm_reg <= S_COPY_WR;
                S_COPY_WR:
                begin
                    fsm_reg <= S_COPY_RD;
                    if (cell_last_col)
                    begin
                        cx_reg <= '0;
                        if (cell_last_row)
                        begin
                            cy_reg        <= '0;
                            fsm_reg       <= S_IDLE;
                            out_valid_reg <= 1'b1;
                        end
                        else
                            cy_reg <= cy_reg + RB'(1);
                    end
                    else
                        cx_reg <= cx_reg + CB'(1);
                end
                default: fsm_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/gca_checker.sv
module gca_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transfer withdrawn before it was taken");

    // A waiting result holds its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result transfer changed while waiting");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("configuration port not ready");

    // A cell write finishes in the cycle after its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[1:0] == gca_pkg::OP_WRITE) |=> m_tvalid)
        else $error("cell write result missing");

    // An in-range cell read waits for the registered memory read before its result shows.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[1:0] == gca_pkg::OP_READ) |=> ##[0:1] m_tvalid)
        else $error("cell read result missing");

endmodule

bind generations_cellular_automaton_unit gca_checker u_gca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: verif/generations_cellular_automaton_unit_checker.sv
`timescale 1ns / 100ps

module generations_cellular_automaton_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0]       read_state;
        gca_pkg::status_t status;
    } cell_result_t;

    logic [7:0] cur_cells [0:65535];
    logic [7:0] nxt_cells [0:65535];
    cell_result_t expected_results [$];

    int state_count;
    int birth_low;
    int birth_high;
    int survive_low;
    int survive_high;
    int wrap_edges;
    int grid_width;
    int grid_height;

    function automatic int extent_of(input int value, input int limit);
        if (value == 0)
            return 1;
        if (value > limit)
            return limit;
        return value;
    endfunction

    function automatic int edge_fix(input int v, input int ext, input bit wrap);
        if (v < 0)
            return wrap ? ext - 1 : 0;
        if (v >= ext)
            return wrap ? 0 : ext - 1;
        return v;
    endfunction

    function automatic logic [15:0] cell_at(input int x, input int y);
        return 16'(y * 256 + x);
    endfunction

    function automatic void advance_grid(input int w, input int h);
        int live;
        int s;
        int nv;
        int adv;
        int nx;
        int ny;
        for (int y = 0; y < h; y++)
        begin
            for (int x = 0; x < w; x++)
            begin
                live = 0;
                s = int'(cur_cells[cell_at(x, y)]);
                for (int oy = -1; oy <= 1; oy++)
                begin
                    for (int ox = -1; ox <= 1; ox++)
                    begin
                        if (ox != 0 || oy != 0)
                        begin
                            nx = edge_fix(x + ox, w, wrap_edges[0]);
                            ny = edge_fix(y + oy, h, wrap_edges[0]);
                            if (cur_cells[cell_at(nx, ny)] == 8'd1)
                                live++;
                        end
                    end
                end
                if (s == 0)
                    nv = (live >= birth_low && live <= birth_high) ? 1 : 0;
                else if (s == 1)
                begin
                    if (live >= survive_low && live <= survive_high)
                        nv = 1;
                    else
                        nv = (state_count > 2) ? 2 : 0;
                end
                else
                begin
                    adv = s + 1;
                    nv = (adv < state_count && adv <= 255) ? adv : 0;
                end
                nxt_cells[cell_at(x, y)] = nv[7:0];
            end
        end
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                cur_cells[cell_at(x, y)] = nxt_cells[cell_at(x, y)];
    endfunction

    function automatic cell_result_t predict_cell_op(input logic [31:0] item);
        cell_result_t r;
        logic [1:0] op;
        int col;
        int row;
        int w;
        int h;
        op = item[1:0];
        col = int'(item[9:2]);
        row = int'(item[17:10]);
        w = extent_of(grid_width, 256);
        h = extent_of(grid_height, 256);
        r.read_state = 8'd0;
        r.status = gca_pkg::ST_OK;
        if (op == gca_pkg::OP_WRITE || op == gca_pkg::OP_READ)
        begin
            if (col >= w || row >= h)
                r.status = gca_pkg::ST_RANGE;
            else if (op == gca_pkg::OP_WRITE)
                cur_cells[cell_at(col, row)] = item[25:18];
            else
                r.read_state = cur_cells[cell_at(col, row)];
        end
        else if (op == gca_pkg::OP_STEP)
        begin
            if (birth_low > birth_high || survive_low > survive_high)
                r.status = gca_pkg::ST_BAD_RULE;
            else
                advance_grid(w, h);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < 65536; i++)
                cur_cells[16'(i)] = 8'd0;
            state_count = 2;
            birth_low = 3;
            birth_high = 3;
            survive_low = 2;
            survive_high = 3;
            wrap_edges = 1;
            grid_width = 256;
            grid_height = 256;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (gca_pkg::reg_idx_t'(paddr[4:2]))
                    gca_pkg::REG_STATE_COUNT:  state_count = int'(pwdata[8:0]);
                    gca_pkg::REG_BIRTH_LOW:    birth_low = int'(pwdata[3:0]);
                    gca_pkg::REG_BIRTH_HIGH:   birth_high = int'(pwdata[3:0]);
                    gca_pkg::REG_SURVIVE_LOW:  survive_low = int'(pwdata[3:0]);
                    gca_pkg::REG_SURVIVE_HIGH: survive_high = int'(pwdata[3:0]);
                    gca_pkg::REG_WRAP_EDGES:   wrap_edges = int'(pwdata[0]);
                    gca_pkg::REG_GRID_WIDTH:   grid_width = int'(pwdata[8:0]);
                    gca_pkg::REG_GRID_HEIGHT:  grid_height = int'(pwdata[8:0]);
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transfer %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_tdata[7:0] !== exp_r.read_state)
                    begin
                        $display("%0t: read_state expected %h actual %h",
                                 $time, exp_r.read_state, m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[9:8] !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_r.status, m_tdata[9:8]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(), predict_cell_op(s_tdata));
            pending = expected_results.size();
        end
    end

endmodule

FILE: verif/generations_cellular_automaton_unit_test.sv
`timescale 1ns / 100ps

module generations_cellular_automaton_unit_test;

    localparam int CYCLE_LIMIT = 5000000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    int fail_count;
    int pending;
    int cycles = 0;
    int out_stall = 0;
    bit quiet;
    int active_w;
    int active_h;

    generations_cellular_automaton_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    generations_cellular_automaton_unit_checker checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("generations_cellular_automaton_unit_test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                out_stall = quiet ? 0 : $urandom_range(0, 10);
            if (out_stall > 0)
            begin
                out_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic write_reg(input gca_pkg::reg_idx_t idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_grid(input int w, input int h, input int wrap);
        write_reg(gca_pkg::REG_GRID_WIDTH, w);
        write_reg(gca_pkg::REG_GRID_HEIGHT, h);
        write_reg(gca_pkg::REG_WRAP_EDGES, wrap);
        active_w = (w == 0) ? 1 : (w > 256) ? 256 : w;
        active_h = (h == 0) ? 1 : (h > 256) ? 256 : h;
    endtask

    task automatic set_rules(input int cnt, input int bl, input int bh,
                             input int sl, input int sh);
        write_reg(gca_pkg::REG_STATE_COUNT, cnt);
        write_reg(gca_pkg::REG_BIRTH_LOW, bl);
        write_reg(gca_pkg::REG_BIRTH_HIGH, bh);
        write_reg(gca_pkg::REG_SURVIVE_LOW, sl);
        write_reg(gca_pkg::REG_SURVIVE_HIGH, sh);
    endtask

    task automatic send_item(input logic [1:0] op, input logic [7:0] col,
                             input logic [7:0] row, input logic [7:0] cell_value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, cell_value, row, col, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] draw_cell_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 8'd0;
        if (pick < 75)
            return 8'd1;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_phase(input int item_count);
        int pick;
        int w;
        int h;
        int cnt;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            w = (pick == 0 && $urandom_range(0, 1)) ? 256 : $urandom_range(257, 511);
            h = $urandom_range(0, 2);
        end
        else
        begin
            w = $urandom_range(0, 8);
            h = $urandom_range(0, 8);
        end
        pick = $urandom_range(0, 3);
        cnt = (pick == 0) ? 2 : (pick == 1) ? 3 : (pick == 2) ? 256 : $urandom_range(2, 256);
        set_grid(w, h, $urandom_range(0, 1));
        set_rules(cnt, $urandom_range(0, 9), $urandom_range(0, 9),
                  $urandom_range(0, 9), $urandom_range(0, 9));
        quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < item_count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_item(gca_pkg::OP_WRITE, 8'($urandom_range(0, active_w - 1)),
                          8'($urandom_range(0, active_h - 1)), draw_cell_value());
            else if (pick < 65)
                send_item(gca_pkg::OP_READ, 8'($urandom_range(0, active_w - 1)),
                          8'($urandom_range(0, active_h - 1)), 8'($urandom_range(0, 255)));
            else if (pick < 85)
                send_item(gca_pkg::OP_STEP, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else if (pick < 93)
                send_item($urandom_range(0, 1) ? gca_pkg::OP_WRITE : gca_pkg::OP_READ,
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)));
            else
                send_item(gca_pkg::OP_NOP, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        wait_idle();
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 5'd0;
        pwdata = 32'd0;
        s_tvalid = 1'b0;
        s_tdata = 32'd0;
        quiet = 1'b0;
        active_w = 256;
        active_h = 256;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(gca_pkg::OP_WRITE, 8'd0, 8'd0, 8'd1);
        send_item(gca_pkg::OP_WRITE, 8'd255, 8'd255, 8'd255);
        send_item(gca_pkg::OP_READ, 8'd0, 8'd0, 8'd0);
        send_item(gca_pkg::OP_READ, 8'd255, 8'd255, 8'hFF);
        send_item(gca_pkg::OP_READ, 8'd17, 8'd200, 8'd0);
        send_item(gca_pkg::OP_NOP, 8'hFF, 8'hFF, 8'hFF);
        wait_idle();

        set_grid(4, 4, 1);
        set_rules(3, 3, 3, 2, 3);
        send_item(gca_pkg::OP_WRITE, 8'd1, 8'd0, 8'd1);
        send_item(gca_pkg::OP_WRITE, 8'd1, 8'd1, 8'd1);
        send_item(gca_pkg::OP_WRITE, 8'd1, 8'd2, 8'd1);
        send_item(gca_pkg::OP_STEP, 8'd0, 8'd0, 8'd0);
        send_item(gca_pkg::OP_READ, 8'd0, 8'd1, 8'd0);
        send_item(gca_pkg::OP_READ, 8'd1, 8'd0, 8'd0);
        send_item(gca_pkg::OP_WRITE, 8'd4, 8'd0, 8'd1);
        send_item(gca_pkg::OP_READ, 8'd0, 8'd4, 8'd0);
        wait_idle();

        set_rules(3, 5, 4, 2, 3);
        send_item(gca_pkg::OP_STEP, 8'd0, 8'd0, 8'd0);
        wait_idle();
        set_rules(3, 3, 3, 9, 0);
        send_item(gca_pkg::OP_STEP, 8'd0, 8'd0, 8'd0);
        send_item(gca_pkg::OP_READ, 8'd1, 8'd1, 8'd0);
        wait_idle();

        set_grid(0, 0, 0);
        set_rules(2, 0, 9, 8, 8);
        send_item(gca_pkg::OP_WRITE, 8'd0, 8'd0, 8'd1);
        send_item(gca_pkg::OP_STEP, 8'd0, 8'd0, 8'd0);
        send_item(gca_pkg::OP_READ, 8'd0, 8'd0, 8'd0);
        wait_idle();

        set_rules(256, 9, 9, 0, 0);
        send_item(gca_pkg::OP_WRITE, 8'd0, 8'd0, 8'd254);
        send_item(gca_pkg::OP_STEP, 8'd0, 8'd0, 8'd0);
        send_item(gca_pkg::OP_STEP, 8'd0, 8'd0, 8'd0);
        send_item(gca_pkg::OP_READ, 8'd0, 8'd0, 8'd0);
        wait_idle();

        set_grid(300, 1, 1);
        set_rules(4, 1, 2, 0, 9);
        send_item(gca_pkg::OP_WRITE, 8'd255, 8'd0, 8'd1);
        send_item(gca_pkg::OP_STEP, 8'd0, 8'd0, 8'd0);
        send_item(gca_pkg::OP_READ, 8'd0, 8'd0, 8'd0);
        wait_idle();

        for (int p = 0; p < 5; p++)
            random_phase(15);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("generations_cellular_automaton_unit_test passed");
        else
            $display("generations_cellular_automaton_unit_test failed");
        $finish;
    end

endmodule
